[design/psf_pkg.sv]
// ----------------------------------------------------------------------------
// psf_pkg
// Shared constants and types for the palindrome substring finder.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int IL_DEPTH    = 2 * MAX_SYMBOLS + 1;

  localparam int SYM_W  = 21;
  localparam int CNT_W  = 6;
  localparam int POS_W  = 7;
  localparam int RAD_W  = 6;
  localparam int IDX_W  = 5;
  localparam int MIN_W  = 6;
  localparam int SYM_AW = $clog2(MAX_SYMBOLS);
  localparam int RAD_AW = $clog2(IL_DEPTH);

  localparam logic [MIN_W-1:0] MIN_LENGTH_RESET = MIN_W'(3);

  // result handed from the search engine to the output stage
  typedef struct packed {
    logic             valid;
    logic             final_res;
    logic [IDX_W-1:0] start;
    logic [RAD_W-1:0] len;
  } res_push_t;

endpackage

`default_nettype wire

[design/psf_ram.sv]
// ----------------------------------------------------------------------------
// psf_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

[design/psf_search.sv]
// ----------------------------------------------------------------------------
// psf_search
// Symbol loading and Manacher center sweep over the implied interleaved
// string, with symbol and radius memories.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_search import psf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             last,
  input  wire logic [MIN_W-1:0] minl,
  output res_push_t             push,
  input  wire logic             push_ack
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MIRROR = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_EXP    = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]       state;
  logic [CNT_W-1:0] symbol_count;
  logic [CNT_W-1:0] n;
  logic [POS_W-1:0] i;
  logic [POS_W-1:0] best_center;
  logic [POS_W-1:0] right_edge;
  logic [RAD_W-1:0] r;
  logic             use_mirror;

  logic             accept;
  logic             not_full;
  logic [CNT_W-1:0] count_next;
  logic [POS_W-1:0] t_len;
  logic [8:0]       mirror;
  logic [7:0]       p1;
  logic [7:0]       p2;
  logic             lo_ok;
  logic             hi_ok;
  logic [POS_W-1:0] span;
  logic [RAD_W-1:0] pm;
  logic [RAD_W-1:0] pm_b;
  logic [RAD_W-1:0] r_init;
  logic [7:0]       reach;
  logic [POS_W-1:0] lead;
  logic             hit;
  logic [SYM_W-1:0] sym_a;
  logic [SYM_W-1:0] sym_b;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign not_full   = (symbol_count < CNT_W'(MAX_SYMBOLS));
  assign count_next = not_full ? symbol_count + CNT_W'(1) : symbol_count;
  assign t_len      = {n, 1'b1};

  assign mirror = {1'b0, best_center, 1'b0} - {2'b00, i};
  assign p1     = {1'b0, i} - {2'b00, r} - 8'd1;
  assign p2     = {1'b0, i} + {2'b00, r} + 8'd1;
  assign lo_ok  = ({1'b0, i} >= ({2'b00, r} + 8'd1));
  assign hi_ok  = (p2 < {1'b0, t_len});
  assign span   = right_edge - i;
  assign r_init = (span < {1'b0, pm}) ? span[RAD_W-1:0] : pm_b;
  assign reach  = {1'b0, i} + {2'b00, r};
  assign lead   = i - POS_W'(r);
  assign hit    = (r >= minl);

  psf_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_sym_ram (
    .clk       (clk),
    .we        (accept && not_full),
    .wr_addr   (symbol_count[SYM_AW-1:0]),
    .wr_data   (symbol),
    .rd_addr_a (p1[SYM_AW:1]),
    .rd_data_a (sym_a),
    .rd_addr_b (p2[SYM_AW:1]),
    .rd_data_b (sym_b)
  );

  psf_ram #(.WIDTH(RAD_W), .DEPTH(IL_DEPTH)) u_rad_ram (
    .clk       (clk),
    .we        (state == S_DONE),
    .wr_addr   (i[RAD_AW-1:0]),
    .wr_data   (r),
    .rd_addr_a (mirror[RAD_AW-1:0]),
    .rd_data_a (pm),
    .rd_addr_b (mirror[RAD_AW-1:0]),
    .rd_data_b (pm_b)
  );

  always_comb begin
    push.valid     = 1'b0;
    push.final_res = 1'b0;
    push.start     = lead[IDX_W:1];
    push.len       = r;
    case (state)
      S_DONE: push.valid = hit;
      S_FIN: begin
        push.valid     = 1'b1;
        push.final_res = 1'b1;
      end
      default: push.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      symbol_count <= '0;
      n            <= '0;
      i            <= '0;
      best_center  <= '0;
      right_edge   <= '0;
      r            <= '0;
      use_mirror   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (last) begin
              symbol_count <= '0;
              n            <= count_next;
              i            <= '0;
              best_center  <= '0;
              right_edge   <= '0;
              state        <= (count_next >= minl) ? S_MIRROR : S_FIN;
            end else begin
              symbol_count <= count_next;
            end
          end
        end
        S_MIRROR: begin
          use_mirror <= (i < right_edge) && !mirror[8] && (mirror < 9'(IL_DEPTH));
          state      <= S_INIT;
        end
        S_INIT: begin
          r     <= use_mirror ? r_init : '0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (!(lo_ok && hi_ok)) begin
            state <= S_DONE;
          end else if (!p1[0]) begin
            r <= r + RAD_W'(1);
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (sym_a == sym_b) begin
            r     <= r + RAD_W'(1);
            state <= S_EXP;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!hit || push_ack) begin
            if (reach > {1'b0, right_edge}) begin
              best_center <= i;
              right_edge  <= reach[POS_W-1:0];
            end
            if (i == {n, 1'b0}) begin
              state <= S_FIN;
            end else begin
              i     <= i + POS_W'(1);
              state <= S_MIRROR;
            end
          end
        end
        S_FIN: begin
          if (push_ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/psf_outbuf.sv]
// ----------------------------------------------------------------------------
// psf_outbuf
// Holds one result back so the final one of a run can be flagged, and
// drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_outbuf import psf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire res_push_t        push,
  output logic                  push_ack,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  found,
  output logic      [IDX_W-1:0] start_index,
  output logic      [RAD_W-1:0] pal_length,
  output logic                  end_of_run
);

  logic             pend_valid;
  logic [IDX_W-1:0] pend_start;
  logic [RAD_W-1:0] pend_len;
  logic             slot_free;
  logic             load_out;

  assign slot_free = !out_valid || out_ready;
  assign push_ack  = push.valid &&
                     ((push.final_res || pend_valid) ? slot_free : 1'b1);
  assign load_out  = push_ack && (push.final_res || pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (push_ack) begin
        pend_valid <= !push.final_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ack && !push.final_res) begin
      pend_start <= push.start;
      pend_len   <= push.len;
    end
    if (load_out) begin
      found       <= pend_valid;
      start_index <= pend_valid ? pend_start : '0;
      pal_length  <= pend_valid ? pend_len : '0;
      end_of_run  <= push.final_res;
    end
  end

endmodule

`default_nettype wire

[design/palindrome_substring_finder.sv]
// ----------------------------------------------------------------------------
// palindrome_substring_finder
// Loads a symbol string and reports its palindromic substrings (Manacher).
// ----------------------------------------------------------------------------
// Loading: one symbol per cycle; in_ready drops from the last beat until the
// search ends. Search: 2n+1 centers, each passing the mirror, init, expand and
// done states, with an extra expand step per separator and a compare state per
// symbol pair, as the memory reads are registered; output stalls hold done.
// First result appears after the second hit (one result is held back), the
// last after the sweep ends. Sync reset clears control state and
// sets min_length to 3; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module palindrome_substring_finder import psf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [MIN_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  found,
  output logic      [IDX_W-1:0] start_index,
  output logic      [RAD_W-1:0] pal_length,
  output logic                  end_of_run
);

  logic [MIN_W-1:0] min_length;
  logic [MIN_W-1:0] minl;
  res_push_t        push;
  logic             push_ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      min_length <= cfg_data;
    end
  end

  assign minl = (min_length == '0) ? MIN_W'(1) : min_length;

  psf_search u_search (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .symbol   (symbol),
    .last     (last),
    .minl     (minl),
    .push     (push),
    .push_ack (push_ack)
  );

  psf_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_ack    (push_ack),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .start_index (start_index),
    .pal_length  (pal_length),
    .end_of_run  (end_of_run)
  );

endmodule

`default_nettype wire

[design/psf_checker.sv]
// ----------------------------------------------------------------------------
// psf_checker
// Port-level checks for the palindrome substring finder.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_checker import psf_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             found,
  input wire logic [IDX_W-1:0] start_index,
  input wire logic [RAD_W-1:0] pal_length,
  input wire logic             end_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before accept");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(found) && $stable(start_index) &&
      $stable(pal_length) && $stable(end_of_run))
    else $error("result beat changed while stalled");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> end_of_run && (pal_length == '0) && (start_index == '0))
    else $error("malformed not-found beat");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (pal_length != '0) &&
      ((7'(start_index) + 7'(pal_length)) <= 7'(MAX_SYMBOLS)))
    else $error("palindrome runs past string end");

endmodule

bind palindrome_substring_finder psf_checker u_psf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .start_index (start_index),
  .pal_length  (pal_length),
  .end_of_run  (end_of_run)
);

`default_nettype wire
